/* rtl/core/nsp_pkg.sv */
// Package for the numeric string parser: parse state type and ASCII codes.
// No dependencies; used by nsp_step and numeric_string_parser_core.
`default_nettype none

package nsp_pkg;

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_LO_A   = 8'h61;
    localparam logic [7:0] CHR_LO_F   = 8'h66;
    localparam logic [7:0] CHR_UP_A   = 8'h41;
    localparam logic [7:0] CHR_UP_F   = 8'h46;
    localparam logic [7:0] CHR_LO_X   = 8'h78;
    localparam logic [7:0] CHR_UP_X   = 8'h58;
    localparam logic [7:0] CHR_LO_K   = 8'h6B;
    localparam logic [7:0] CHR_UP_K   = 8'h4B;
    localparam logic [7:0] CHR_LO_M   = 8'h6D;
    localparam logic [7:0] CHR_UP_M   = 8'h4D;

    // Position just past the "0x" prefix.
    localparam logic [3:0] POS_AFTER_PREFIX = 4'd2;
    localparam logic [3:0] POS_MAX          = 4'd15;

    localparam int unsigned KILO_SHIFT = 10;
    localparam int unsigned MEGA_SHIFT = 20;

    typedef struct packed {
        logic [3:0]  position;
        logic        hex_mode;
        logic        first_was_zero;
        logic        verdict_given;
        logic [31:0] accumulator;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        logic        accepted;
        logic [31:0] value;
    } verdict_t;

endpackage

`default_nettype wire

/* rtl/core/nsp_step.sv */
// One parse step: next parse state and verdict for one character.
// Depends on nsp_pkg.
`default_nettype none

module nsp_step #(
    parameter int MAX_CHARS = 11
) (
    input  wire nsp_pkg::parse_state_t state_in,
    input  wire                        start_req,
    input  wire [7:0]                  char_in,
    output nsp_pkg::parse_state_t      state_out,
    output nsp_pkg::verdict_t          verdict
);

    localparam logic [3:0] POS_LIMIT = 4'(MAX_CHARS - 1);

    nsp_pkg::parse_state_t cur;
    logic       is_dec;
    logic       is_lo_hex;
    logic       is_up_hex;
    logic [3:0] nibble;
    logic [3:0] pos_inc;
    logic [31:0] acc_dec;
    logic [31:0] acc_hex;

    always_comb begin
        cur = start_req ? '0 : state_in;
        is_dec    = (char_in >= nsp_pkg::CHR_ZERO) && (char_in <= nsp_pkg::CHR_NINE);
        is_lo_hex = (char_in >= nsp_pkg::CHR_LO_A) && (char_in <= nsp_pkg::CHR_LO_F);
        is_up_hex = (char_in >= nsp_pkg::CHR_UP_A) && (char_in <= nsp_pkg::CHR_UP_F);
        if (is_dec) begin
            nibble = 4'(char_in - nsp_pkg::CHR_ZERO);
        end else if (is_lo_hex) begin
            nibble = 4'(char_in - nsp_pkg::CHR_LO_A + 8'd10);
        end else begin
            nibble = 4'(char_in - nsp_pkg::CHR_UP_A + 8'd10);
        end
        pos_inc = (cur.position < nsp_pkg::POS_MAX) ? cur.position + 4'd1 : cur.position;
        // Multiply by ten as a sum of two shifts.
        acc_dec = (cur.accumulator << 3) + (cur.accumulator << 1)
                + {28'd0, nibble};
        acc_hex = (cur.accumulator << 4) + {28'd0, nibble};
    end

    always_comb begin
        state_out = cur;
        verdict   = '0;
        if (!start_req && state_in.verdict_given) begin
            // The string is already decided; the character is dropped.
            state_out = state_in;
        end else if (cur.hex_mode) begin
            if (char_in == nsp_pkg::CHR_NUL) begin
                verdict.emit     = 1'b1;
                verdict.accepted = (cur.position != nsp_pkg::POS_AFTER_PREFIX);
                verdict.value    = verdict.accepted ? cur.accumulator : 32'd0;
            end else if (!(is_dec || is_lo_hex || is_up_hex)
                         || cur.position >= POS_LIMIT) begin
                verdict.emit = 1'b1;
            end else begin
                state_out.accumulator = acc_hex;
                state_out.position    = pos_inc;
            end
        end else if (cur.position == 4'd1 && cur.first_was_zero
                     && (char_in == nsp_pkg::CHR_LO_X || char_in == nsp_pkg::CHR_UP_X)) begin
            state_out.hex_mode    = 1'b1;
            state_out.accumulator = 32'd0;
            state_out.position    = nsp_pkg::POS_AFTER_PREFIX;
        end else if (char_in == nsp_pkg::CHR_NUL) begin
            verdict.emit     = 1'b1;
            verdict.accepted = 1'b1;
            verdict.value    = cur.accumulator;
        end else if ((char_in == nsp_pkg::CHR_LO_K || char_in == nsp_pkg::CHR_UP_K)
                     && cur.position != 4'd0) begin
            verdict.emit     = 1'b1;
            verdict.accepted = 1'b1;
            verdict.value    = cur.accumulator << nsp_pkg::KILO_SHIFT;
        end else if ((char_in == nsp_pkg::CHR_LO_M || char_in == nsp_pkg::CHR_UP_M)
                     && cur.position != 4'd0) begin
            verdict.emit     = 1'b1;
            verdict.accepted = 1'b1;
            verdict.value    = cur.accumulator << nsp_pkg::MEGA_SHIFT;
        end else if (!is_dec || cur.position >= POS_LIMIT) begin
            verdict.emit = 1'b1;
        end else begin
            state_out.accumulator = acc_dec;
            if (cur.position == 4'd0) begin
                state_out.first_was_zero = (char_in == nsp_pkg::CHR_ZERO);
            end
            state_out.position = pos_inc;
        end
        if (verdict.emit) begin
            state_out.verdict_given = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/numeric_string_parser_core.sv */
// Top level of the numeric string parser: input register, parse step, result register.
// Depends on nsp_pkg and nsp_step.
//
//   channel   direction  payload                 notes
//   s_*       in         s_start_req, s_char_in  one character per transfer
//   m_*       out        m_accepted, m_value     one verdict per string
//
// A character passes from the character register through the parse step to the
// result register; one character is taken every cycle while the result is not stalled.
// Reset (aresetn low, synchronous) empties both registers and clears the parse state.
// A stalled result holds the character register; the input side stalls only when
// both the character register and the result register are full.
`default_nettype none

module numeric_string_parser_core #(
    parameter int MAX_CHARS = 11
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_start_req,
    input  wire [7:0]   s_char_in,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_accepted,
    output logic [31:0] m_value
);

    logic                  in_valid_reg;
    logic                  start_reg;
    logic [7:0]            char_reg;
    logic                  out_valid_reg;
    logic                  accepted_reg;
    logic [31:0]           value_reg;
    nsp_pkg::parse_state_t state_reg;
    nsp_pkg::parse_state_t state_next;
    nsp_pkg::verdict_t     verdict;
    logic                  advance;

    nsp_step #(
        .MAX_CHARS(MAX_CHARS)
    ) u_step (
        .state_in (state_reg),
        .start_req(start_reg),
        .char_in  (char_reg),
        .state_out(state_next),
        .verdict  (verdict)
    );

    // The held character moves on whenever the result slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && verdict.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            start_reg <= s_start_req;
            char_reg  <= s_char_in;
        end
        if (advance && verdict.emit) begin
            accepted_reg <= verdict.accepted;
            value_reg    <= verdict.value;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_accepted = accepted_reg;
    assign m_value    = value_reg;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !accepted_reg |-> value_reg == 32'd0)
        else $error("rejected result carries a nonzero value");

    a_verdict_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && verdict.emit |=> state_reg.verdict_given)
        else $error("verdict given without marking the string decided");

    a_hex_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hex_mode |-> state_reg.position >= nsp_pkg::POS_AFTER_PREFIX)
        else $error("hex mode with position before the prefix end");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled while the result slot is empty");
`endif

endmodule

`default_nettype wire
